>>> design/bfsk_pkg.sv
package bfsk_pkg;

	// Default sizes
	localparam int PHASE_BITS_DEF      = 32;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 16;

	// Configuration port
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_PREAMBLE_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SYMBOL_LENGTH   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MARK_STEP       = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPACE_STEP      = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TONE_AMPLITUDE  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SYNC_PATTERN    = 3'd5;

	// Register reset values
	localparam logic [9:0]  PREAMBLE_LENGTH_RST = 10'd64;
	localparam logic [9:0]  SYMBOL_LENGTH_RST   = 10'd16;
	localparam logic [31:0] MARK_STEP_RST       = 32'd0;
	localparam logic [31:0] SPACE_STEP_RST      = 32'd0;
	localparam logic [14:0] TONE_AMPLITUDE_RST  = 15'd16384;
	localparam logic [31:0] SYNC_PATTERN_RST    = 32'd0;

	// Request commands
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Sine table entries are Q15 magnitudes
	localparam int TABLE_WIDTH = 15;

	// pi/2 in Q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Flags that follow a tick down the sample pipeline
	typedef struct packed {
		logic sent;
		logic want;
		logic neg;
	} tick_flags_t;

	// Quarter-wave entry k of a 2^table_bits table: odd Taylor series to x^13 in Q30,
	// truncating each term, rounded half up to Q15 and saturated.
	function automatic logic [TABLE_WIDTH-1:0] sine_q15(int unsigned k, int unsigned table_bits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		x    = (longint'(k) * HALF_PI_Q30) >> table_bits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 6;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 110;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 156;
		sum  = sum + term;
		sum  = (sum + 64'd16384) >> 15;
		if (sum > 64'd32767) begin
			sum = 64'd32767;
		end
		return TABLE_WIDTH'(sum);
	endfunction

endpackage

>>> design/bfsk_ifs.sv
// Request channel: one byte delivery or one sample tick
interface bfsk_item_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] byte_value;
	logic       frame_start;

	modport source (output valid, output command, output byte_value, output frame_start,
		input ready);
	modport sink (input valid, input command, input byte_value, input frame_start,
		output ready);
endinterface

// Result channel: one sample per tick
interface bfsk_result_if #(
	parameter int SAMPLE_BITS = bfsk_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          frame_active;
	logic                          want_byte;

	modport source (output valid, output sample_out, output frame_active, output want_byte,
		input ready);
	modport sink (input valid, input sample_out, input frame_active, input want_byte,
		output ready);
endinterface

>>> design/bfsk_sine_rom.sv
// Quarter-wave sine table, 2^TABLE_BITS + 1 entries, registered read
module bfsk_sine_rom #(
	parameter int TABLE_BITS = bfsk_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [TABLE_BITS:0]                addr,
	output logic [bfsk_pkg::TABLE_WIDTH-1:0]   data
);

	localparam int DEPTH = (1 << TABLE_BITS) + 1;

	logic [bfsk_pkg::TABLE_WIDTH-1:0] entries [DEPTH];

	// Contents settle at elaboration
	for (genvar k = 0; k < DEPTH; k++) begin : g_entry
		assign entries[k] = bfsk_pkg::sine_q15(k, TABLE_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data <= entries[addr];
		end
	end

endmodule

>>> design/bfsk_frame_modulator.sv
// Continuous-phase binary FSK frame modulator.
// Requests arrive on 'items': command 0 delivers a frame byte (frame_start = 1
// restarts the frame and zeroes the phase), command 1 is one sample tick.
// Each tick gives one result on 'results'; a byte delivery gives none.
// Registers are to be written by the user through wr_en / wr_index / wr_data
// only while the block is idle; the block does not enforce this. Throughput:
// one request per cycle while the receiver keeps up. The bit sequencer and phase
// accumulator update at the edge that takes a request, which also loads the table
// address stage; table read, amplitude multiply and the output register follow.
// If the receiver stalls, the output holds its sample and the pipeline stages
// fill up behind it; requests are still taken until every stage holds a tick,
// then items.ready drops until results.ready returns.
// Reset (arst_n low) clears the frame state, the phase and the byte holder,
// empties the pipeline and loads the register defaults (preamble 64 bits,
// 16 ticks per bit, amplitude 16384, zero steps and sync word).
module bfsk_frame_modulator #(
	parameter int PHASE_BITS      = bfsk_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = bfsk_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = bfsk_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [bfsk_pkg::CFG_INDEX_BITS-1:0]   wr_index,
	input  logic [bfsk_pkg::CFG_DATA_BITS-1:0]    wr_data,
	bfsk_item_if.sink                             items,
	bfsk_result_if.source                         results
);

	localparam int TB = SINE_TABLE_BITS;
	localparam int TW = bfsk_pkg::TABLE_WIDTH;
	localparam logic [TB:0] QSIZE = {1'b1, {TB{1'b0}}};

	// Configuration registers
	logic [9:0]    preamble_len_q;
	logic [9:0]    symbol_len_q;
	logic [31:0]   mark_step_q;
	logic [31:0]   space_step_q;
	logic [14:0]   amplitude_q;
	logic [31:0]   sync_pattern_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_len_q <= bfsk_pkg::PREAMBLE_LENGTH_RST;
			symbol_len_q   <= bfsk_pkg::SYMBOL_LENGTH_RST;
			mark_step_q    <= bfsk_pkg::MARK_STEP_RST;
			space_step_q   <= bfsk_pkg::SPACE_STEP_RST;
			amplitude_q    <= bfsk_pkg::TONE_AMPLITUDE_RST;
			sync_pattern_q <= bfsk_pkg::SYNC_PATTERN_RST;
		end else if (wr_en) begin
			case (wr_index)
				bfsk_pkg::REG_PREAMBLE_LENGTH: preamble_len_q <= wr_data[9:0];
				bfsk_pkg::REG_SYMBOL_LENGTH:   symbol_len_q   <= wr_data[9:0];
				bfsk_pkg::REG_MARK_STEP:       mark_step_q    <= wr_data[31:0];
				bfsk_pkg::REG_SPACE_STEP:      space_step_q   <= wr_data[31:0];
				bfsk_pkg::REG_TONE_AMPLITUDE:  amplitude_q    <= wr_data[14:0];
				bfsk_pkg::REG_SYNC_PATTERN:    sync_pattern_q <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	// Frame state
	logic [PHASE_BITS-1:0] phase_q,     phase_d;
	logic [9:0]            pre_rem_q,   pre_rem_d;
	logic [9:0]            pre_idx_q,   pre_idx_d;
	logic [5:0]            sync_rem_q,  sync_rem_d;
	logic [7:0]            shift_q,     shift_d;
	logic [3:0]            bits_left_q, bits_left_d;
	logic [7:0]            held_byte_q, held_byte_d;
	logic                  held_full_q, held_full_d;
	logic                  cur_bit_q,   cur_bit_d;
	logic [9:0]            tick_q,      tick_d;
	logic                  active_q,    active_d;

	logic                  accept;
	logic                  tick_sent;
	logic                  bit_sel;
	logic                  act_now;
	logic [7:0]            shift_src;
	logic [4:0]            sync_idx;
	logic [9:0]            sym_len;
	logic [10:0]           tick_nxt;
	logic [PHASE_BITS-1:0] step;

	// Pipeline handshake
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;

	assign accept    = items.valid && items.ready;
	assign sync_idx  = 5'(sync_rem_q - 6'd1);
	assign shift_src = (bits_left_q == 4'd0) ? held_byte_q : shift_q;
	assign sym_len   = (symbol_len_q == 10'd0) ? 10'd1 : symbol_len_q;
	assign tick_nxt  = {1'b0, tick_q} + 11'd1;
	assign step      = bit_sel ? PHASE_BITS'(mark_step_q) : PHASE_BITS'(space_step_q);

	// Bit sequencer and phase update for one request
	always_comb begin
		phase_d     = phase_q;
		pre_rem_d   = pre_rem_q;
		pre_idx_d   = pre_idx_q;
		sync_rem_d  = sync_rem_q;
		shift_d     = shift_q;
		bits_left_d = bits_left_q;
		held_byte_d = held_byte_q;
		held_full_d = held_full_q;
		cur_bit_d   = cur_bit_q;
		tick_d      = tick_q;
		active_d    = active_q;
		bit_sel     = cur_bit_q;
		act_now     = active_q;
		tick_sent   = 1'b0;
		if (items.command == bfsk_pkg::CMD_BYTE) begin
			if (items.frame_start) begin
				phase_d     = '0;
				pre_rem_d   = preamble_len_q;
				pre_idx_d   = '0;
				sync_rem_d  = 6'd32;
				shift_d     = '0;
				bits_left_d = '0;
				held_byte_d = items.byte_value;
				held_full_d = 1'b1;
				cur_bit_d   = 1'b0;
				tick_d      = '0;
				active_d    = 1'b1;
			end else if (!held_full_q) begin
				held_byte_d = items.byte_value;
				held_full_d = 1'b1;
			end
		end else begin
			// pick a new bit at the start of a symbol
			if (active_q && tick_q == 10'd0) begin
				if (pre_rem_q != 10'd0) begin
					bit_sel   = pre_idx_q[0];
					pre_idx_d = pre_idx_q + 10'd1;
					pre_rem_d = pre_rem_q - 10'd1;
				end else if (sync_rem_q != 6'd0) begin
					bit_sel    = sync_pattern_q[sync_idx];
					sync_rem_d = sync_rem_q - 6'd1;
				end else if (bits_left_q == 4'd0 && !held_full_q) begin
					// nothing left to send: frame ends
					act_now = 1'b0;
				end else begin
					bit_sel = shift_src[7];
					shift_d = {shift_src[6:0], 1'b0};
					if (bits_left_q == 4'd0) begin
						held_full_d = 1'b0;
						bits_left_d = 4'd7;
					end else begin
						bits_left_d = bits_left_q - 4'd1;
					end
				end
			end
			active_d  = act_now;
			cur_bit_d = bit_sel;
			if (act_now) begin
				tick_sent = 1'b1;
				phase_d   = phase_q + step;
				tick_d    = (tick_nxt >= {1'b0, sym_len}) ? 10'd0 : tick_nxt[9:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			pre_rem_q   <= '0;
			pre_idx_q   <= '0;
			sync_rem_q  <= '0;
			shift_q     <= '0;
			bits_left_q <= '0;
			held_byte_q <= '0;
			held_full_q <= 1'b0;
			cur_bit_q   <= 1'b0;
			tick_q      <= '0;
			active_q    <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			pre_rem_q   <= pre_rem_d;
			pre_idx_q   <= pre_idx_d;
			sync_rem_q  <= sync_rem_d;
			shift_q     <= shift_d;
			bits_left_q <= bits_left_d;
			held_byte_q <= held_byte_d;
			held_full_q <= held_full_d;
			cur_bit_q   <= cur_bit_d;
			tick_q      <= tick_d;
			active_q    <= active_d;
		end
	end

	// Table address from the phase before this tick's advance
	logic [TB+1:0] phase_top;
	logic [TB:0]   tab_addr;

	assign phase_top = phase_q[PHASE_BITS-1 -: TB+2];
	assign tab_addr  = phase_top[TB] ? (QSIZE - {1'b0, phase_top[TB-1:0]})
	                                 : {1'b0, phase_top[TB-1:0]};

	// Stage 1: table address
	logic                  v_s1;
	bfsk_pkg::tick_flags_t flags_s1;
	logic [TB:0]           addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= accept && (items.command == bfsk_pkg::CMD_TICK);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			flags_s1.sent <= tick_sent;
			flags_s1.want <= !held_full_d;
			flags_s1.neg  <= phase_top[TB+1];
			addr_s1       <= tab_addr;
		end
	end

	// Stage 2: table read
	logic                  v_s2;
	bfsk_pkg::tick_flags_t flags_s2;
	logic [TW-1:0]         sine_s2;

	bfsk_sine_rom #(
		.TABLE_BITS (TB)
	) u_sine_rom (
		.clk  (clk),
		.en   (rdy_s2),
		.addr (addr_s1),
		.data (sine_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			flags_s2 <= flags_s1;
		end
	end

	// Stage 3: amplitude scaling, truncated toward zero
	logic                   v_s3;
	bfsk_pkg::tick_flags_t  flags_s3;
	logic [2*TW-1:0]        product;
	logic [SAMPLE_BITS-2:0] mag_s3;

	assign product = (2*TW)'(amplitude_q) * (2*TW)'(sine_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			flags_s3 <= flags_s2;
			mag_s3   <= product[2*TW-1 : 31-SAMPLE_BITS];
		end
	end

	// Output register: quadrant sign, zero when idle
	logic                   out_v_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   out_active_q;
	logic                   out_want_q;
	logic [SAMPLE_BITS-1:0] mag_ext;

	assign mag_ext = {1'b0, mag_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_out) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			if (!flags_s3.sent) begin
				sample_q <= '0;
			end else if (flags_s3.neg) begin
				sample_q <= '0 - mag_ext;
			end else begin
				sample_q <= mag_ext;
			end
			out_active_q <= flags_s3.sent;
			out_want_q   <= flags_s3.want;
		end
	end

	// Each stage moves when the one after it has room
	assign rdy_out = !out_v_q || results.ready;
	assign rdy_s3  = !v_s3 || rdy_out;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;

	assign items.ready          = rdy_s1;
	assign results.valid        = out_v_q;
	assign results.sample_out   = sample_q;
	assign results.frame_active = out_active_q;
	assign results.want_byte    = out_want_q;

endmodule

>>> design/bfsk_checker.sv
// Port-level checks for the FSK modulator
module bfsk_checker #(
	parameter int SAMPLE_BITS = bfsk_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] sample_out,
	input logic                   frame_active,
	input logic                   want_byte
);

	// no result on the edge after reset has been seen
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	// a tick outside a frame carries a silent sample
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_active) |-> (sample_out == '0))
		else $error("non-zero sample outside a frame");

	// requests are refused only when the whole pipeline is backed up
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("request refused without a stalled result");

	// a stalled result holds
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(sample_out) && $stable(frame_active) && $stable(want_byte)))
		else $error("stalled result changed");

endmodule

bind bfsk_frame_modulator bfsk_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_bfsk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (items.valid),
	.in_ready     (items.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.sample_out   (results.sample_out),
	.frame_active (results.frame_active),
	.want_byte    (results.want_byte)
);

>>> dv/testbench.sv
module testbench;

	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned RANDOM_REQS  = 290;
	localparam int unsigned QUARTER      = 1024;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

	typedef struct packed {
		logic       command;
		logic [7:0] byte_value;
		logic       frame_start;
	} fsk_req_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               frame_active;
		logic               want_byte;
	} tick_result_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                wr_en;
	logic [bfsk_pkg::CFG_INDEX_BITS-1:0] wr_index;
	logic [bfsk_pkg::CFG_DATA_BITS-1:0]  wr_data;

	bfsk_item_if   items_if ();
	bfsk_result_if results_if ();

	bfsk_frame_modulator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.items    (items_if),
		.results  (results_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting to be offered, samples waiting to come back
	fsk_req_t     pending_reqs[$];
	tick_result_t expected_samples[$];

	// Modulator copy: registers
	logic [9:0]  cfg_pre, cfg_sym;
	logic [31:0] cfg_mark, cfg_space, cfg_sync;
	logic [14:0] cfg_amp;

	// Modulator copy: frame state
	logic [31:0] phase_acc;
	logic [9:0]  pre_left, pre_idx, tick_cnt;
	logic [5:0]  sync_left;
	logic [7:0]  shift_byte, held;
	logic [3:0]  bits_left;
	logic        held_full, cur_bit, in_frame;

	logic [14:0] sine_tab [0:QUARTER];

	int unsigned mismatches = 0;
	int unsigned planned_reqs = 0;
	int unsigned ticks_taken = 0, bytes_taken = 0, frames_started = 0;
	int unsigned samples_checked = 0, settings_used = 0;
	int unsigned holds_requested, holds_served, hold_left;
	int unsigned tx_wait = 0, rx_wait = 0, quiet_cycles = 0;
	logic        hold_off, sender_steady;
	bit          offering = 1'b0, tx_steady = 1'b0, rx_steady = 1'b0;
	fsk_req_t     cur_req;
	tick_result_t due;

	// Quarter-wave Q15 entry: odd Taylor series to x^13 in Q30, truncating terms
	function automatic logic [14:0] quarter_sine(input int unsigned k);
		longint unsigned x, x2, term, acc;
		int unsigned n;
		x    = k;
		x    = (x * QUARTER_TURN_Q30) >> 10;
		x2   = (x * x) >> 30;
		term = x;
		acc  = x;
		for (n = 1; n <= 11; n += 2) begin
			term = (term * x2) >> 30;
			term = term / ((n + 1) * (n + 2));
			if ((((n + 1) / 2) % 2) == 1) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		acc = (acc + 64'd16384) >> 15;
		return (acc > 64'd32767) ? 15'd32767 : acc[14:0];
	endfunction

	// Amplitude times sine of the current phase, signed by quadrant
	function automatic logic signed [15:0] tone_sample();
		logic [11:0] top;
		logic [14:0] mag_t;
		logic [29:0] prod;
		logic [15:0] mag;
		top   = phase_acc[31:20];
		mag_t = top[10] ? sine_tab[QUARTER - top[9:0]] : sine_tab[top[9:0]];
		prod  = 30'(cfg_amp) * 30'(mag_t);
		mag   = {1'b0, prod[29:15]};
		return top[11] ? -mag : mag;
	endfunction

	// Advance the modulator copy by one accepted request
	task automatic apply_request(input fsk_req_t r);
		tick_result_t res;
		int unsigned  span;
		if (r.command == bfsk_pkg::CMD_BYTE) begin
			bytes_taken++;
			if (r.frame_start) begin
				frames_started++;
				phase_acc  = '0;
				pre_left   = cfg_pre;
				pre_idx    = '0;
				sync_left  = 6'd32;
				shift_byte = '0;
				bits_left  = '0;
				held       = r.byte_value;
				held_full  = 1'b1;
				cur_bit    = 1'b0;
				tick_cnt   = '0;
				in_frame   = 1'b1;
			end else if (!held_full) begin
				held      = r.byte_value;
				held_full = 1'b1;
			end
		end else begin
			ticks_taken++;
			// choose a bit at a symbol boundary: preamble, sync, shifter, holder
			if (in_frame && tick_cnt == 10'd0) begin
				if (pre_left != 10'd0) begin
					cur_bit  = pre_idx[0];
					pre_idx  = pre_idx + 10'd1;
					pre_left = pre_left - 10'd1;
				end else if (sync_left != 6'd0) begin
					cur_bit   = cfg_sync[sync_left - 6'd1];
					sync_left = sync_left - 6'd1;
				end else begin
					if (bits_left == 4'd0) begin
						if (held_full) begin
							shift_byte = held;
							held_full  = 1'b0;
							bits_left  = 4'd8;
						end else begin
							in_frame = 1'b0;
						end
					end
					if (in_frame) begin
						cur_bit    = shift_byte[7];
						shift_byte = shift_byte << 1;
						bits_left  = bits_left - 4'd1;
					end
				end
			end
			res.sample       = '0;
			res.frame_active = 1'b0;
			if (in_frame) begin
				res.sample       = tone_sample();
				res.frame_active = 1'b1;
				phase_acc        = phase_acc + (cur_bit ? cfg_mark : cfg_space);
				span             = (cfg_sym == 10'd0) ? 1 : cfg_sym;
				if (tick_cnt + 1 >= span) begin
					tick_cnt = '0;
				end else begin
					tick_cnt = tick_cnt + 10'd1;
				end
			end
			res.want_byte = !held_full;
			expected_samples = {expected_samples, res};
		end
	endtask

	function automatic fsk_req_t byte_req(input logic [7:0] b, input logic start);
		fsk_req_t r;
		r.command     = bfsk_pkg::CMD_BYTE;
		r.byte_value  = b;
		r.frame_start = start;
		return r;
	endfunction

	function automatic fsk_req_t tick_req();
		fsk_req_t r;
		r.command     = bfsk_pkg::CMD_TICK;
		r.byte_value  = 8'($urandom);
		r.frame_start = 1'($urandom);
		return r;
	endfunction

	task automatic plan(input fsk_req_t r);
		pending_reqs = {pending_reqs, r};
		planned_reqs++;
	endtask

	task automatic write_reg(input logic [bfsk_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [31:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			bfsk_pkg::REG_PREAMBLE_LENGTH: cfg_pre   = data[9:0];
			bfsk_pkg::REG_SYMBOL_LENGTH:   cfg_sym   = data[9:0];
			bfsk_pkg::REG_MARK_STEP:       cfg_mark  = data;
			bfsk_pkg::REG_SPACE_STEP:      cfg_space = data;
			bfsk_pkg::REG_TONE_AMPLITUDE:  cfg_amp   = data[14:0];
			bfsk_pkg::REG_SYNC_PATTERN:    cfg_sync  = data;
			default: ;
		endcase
	endtask

	task automatic program_config(input logic [31:0] pre, input logic [31:0] sym,
		input logic [31:0] mark, input logic [31:0] space, input logic [31:0] amp,
		input logic [31:0] sync);
		write_reg(bfsk_pkg::REG_PREAMBLE_LENGTH, pre);
		write_reg(bfsk_pkg::REG_SYMBOL_LENGTH, sym);
		write_reg(bfsk_pkg::REG_MARK_STEP, mark);
		write_reg(bfsk_pkg::REG_SPACE_STEP, space);
		write_reg(bfsk_pkg::REG_TONE_AMPLITUDE, amp);
		write_reg(bfsk_pkg::REG_SYNC_PATTERN, sync);
		@(posedge clk);
		wr_en <= 1'b0;
		settings_used++;
	endtask

	// Wait for every request to go in and every sample to come out, then let the pipe drain
	task automatic settle();
		while (pending_reqs.size() != 0 || offering || expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Unused upper bits of a narrow register now and then carry junk
	function automatic logic [31:0] with_junk(input int unsigned value, input logic [31:0] keep);
		if ($urandom_range(0, 3) == 0) begin
			return ($urandom & ~keep) | value;
		end
		return value;
	endfunction

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// One frame: start byte, enough ticks for preamble, sync and n_bytes data bytes,
	// later bytes delivered inside the window in which the holder is empty
	task automatic plan_frame(input int unsigned n_bytes, input int unsigned tail);
		int unsigned span, lead, n_ticks, due_at, sent, i;
		span    = (cfg_sym == 10'd0) ? 1 : cfg_sym;
		lead    = (cfg_pre + 32) * span;
		n_ticks = lead + 8 * n_bytes * span + tail;
		due_at  = lead + 1 + $urandom_range(0, 8 * span - 1);
		sent    = 1;
		plan(byte_req(8'($urandom), 1'b1));
		for (i = 0; i < n_ticks; i++) begin
			if (i == due_at && sent < n_bytes) begin
				// now and then the byte never comes and the frame ends early
				if ($urandom_range(0, 11) != 0) begin
					plan(byte_req(8'($urandom), 1'b0));
				end
				sent++;
				due_at += 8 * span;
			end
			case ($urandom_range(0, 399))
				0, 1, 2, 3: plan(byte_req(8'($urandom), 1'b0));
				4: plan(byte_req(8'($urandom), 1'b1));
				default: ;
			endcase
			plan(tick_req());
		end
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_if.valid       <= 1'b0;
			items_if.command     <= bfsk_pkg::CMD_TICK;
			items_if.byte_value  <= '0;
			items_if.frame_start <= 1'b0;
			offering   = 1'b0;
			tx_wait    = 0;
			cur_req    = byte_req(8'd0, 1'b0);
			phase_acc  = '0;
			pre_left   = '0;
			pre_idx    = '0;
			tick_cnt   = '0;
			sync_left  = '0;
			shift_byte = '0;
			held       = '0;
			bits_left  = '0;
			held_full  = 1'b0;
			cur_bit    = 1'b0;
			in_frame   = 1'b0;
		end else begin
			if (items_if.valid && items_if.ready) begin
				apply_request(cur_req);
				offering = 1'b0;
				if ($urandom_range(0, 39) == 0) begin
					tx_steady = !tx_steady;
				end
				tx_wait = (tx_steady || sender_steady) ? 0 : $urandom_range(0, 12);
			end
			if (!offering) begin
				if (tx_wait != 0) begin
					tx_wait--;
				end else if (pending_reqs.size() != 0) begin
					cur_req  = pending_reqs.pop_front();
					offering = 1'b1;
				end
			end
			items_if.valid       <= offering;
			items_if.command     <= cur_req.command;
			items_if.byte_value  <= cur_req.byte_value;
			items_if.frame_start <= cur_req.frame_start;
		end
	end

	// Long receiver hold-off, started on demand
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off <= 1'b0;
			holds_served = 0;
			hold_left    = 0;
		end else begin
			if (holds_served != holds_requested) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end else if (hold_left != 0) begin
				hold_left--;
			end
			hold_off <= (hold_left != 0);
		end
	end

	// Sample monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (results_if.valid && results_if.ready) begin
				samples_checked++;
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: unexpected sample %0d active %0b want %0b",
							$signed(results_if.sample_out), results_if.frame_active,
							results_if.want_byte);
					end
				end else begin
					due = expected_samples.pop_front();
					if (results_if.sample_out !== due.sample
						|| results_if.frame_active !== due.frame_active
						|| results_if.want_byte !== due.want_byte) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("ERROR: sample %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
								samples_checked, $signed(due.sample), due.frame_active,
								due.want_byte, $signed(results_if.sample_out),
								results_if.frame_active, results_if.want_byte);
						end
					end
				end
				if ($urandom_range(0, 39) == 0) begin
					rx_steady = !rx_steady;
				end
				rx_wait = rx_steady ? 0 : $urandom_range(0, 12);
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			results_if.ready <= (rx_wait == 0) && !hold_off;
		end
	end

	// Watchdog: nothing moving on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (items_if.valid && items_if.ready)
			|| (results_if.valid && results_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no request or sample moved for %0d cycles", QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int unsigned k, random_start;
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = '0;
		wr_data         = '0;
		holds_requested = 0;
		sender_steady   = 1'b0;

		for (k = 0; k <= QUARTER; k++) begin
			sine_tab[k] = quarter_sine(k);
		end
		cfg_pre   = bfsk_pkg::PREAMBLE_LENGTH_RST;
		cfg_sym   = bfsk_pkg::SYMBOL_LENGTH_RST;
		cfg_mark  = bfsk_pkg::MARK_STEP_RST;
		cfg_space = bfsk_pkg::SPACE_STEP_RST;
		cfg_amp   = bfsk_pkg::TONE_AMPLITUDE_RST;
		cfg_sync  = bfsk_pkg::SYNC_PATTERN_RST;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle tick, byte kept while idle, byte dropped on a full holder,
		// frame start, restart mid-frame, plain byte while the holder is full
		program_config(1, 1, 32'h4000_0000, 32'h0123_4567, 32767, 32'hA5C3_0FF0);
		plan(tick_req());
		plan(byte_req(8'hFF, 1'b0));
		plan(byte_req(8'h00, 1'b0));
		plan(tick_req());
		plan(byte_req(8'h80, 1'b1));
		repeat (6) plan(tick_req());
		plan(byte_req(8'h7F, 1'b1));
		repeat (6) plan(tick_req());
		plan(byte_req(8'h55, 1'b0));
		repeat (2) plan(tick_req());
		settle();

		// Random frames over changing settings
		random_start = planned_reqs;
		while (planned_reqs - random_start < RANDOM_REQS) begin
			program_config(
				with_junk(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6), 32'h3FF),
				with_junk(($urandom_range(0, 5) == 0) ? 3 : $urandom_range(0, 2), 32'h3FF),
				random_word(), random_word(),
				with_junk(($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(0, 32767),
					32'h7FFF),
				random_word());
			plan_frame($urandom_range(1, 3), $urandom_range(2, 6));
			if ($urandom_range(0, 1) == 1) begin
				plan_frame($urandom_range(1, 3), $urandom_range(2, 6));
			end
			settle();
		end

		// Longest preamble and symbol, all within the first bit
		program_config(1023, 1023, 32'hFFFF_FFFF, 32'h0000_0001, 32767, 32'hFFFF_FFFF);
		plan(byte_req(8'($urandom), 1'b1));
		repeat (12) plan(tick_req());
		settle();

		// Longest preamble at one tick per bit, zero amplitude, then a restart
		program_config(1023, 1, 32'h0000_0000, 32'hFFFF_FFFF, 0, 32'h0000_0000);
		plan(byte_req(8'($urandom), 1'b1));
		repeat (10) plan(tick_req());
		plan(byte_req(8'($urandom), 1'b1));
		repeat (6) plan(tick_req());
		settle();

		// Back-pressure: receiver holds off while the sender keeps offering
		program_config(0, 0, $urandom, $urandom, 32767, $urandom);
		sender_steady   <= 1'b1;
		holds_requested <= holds_requested + 1;
		plan(byte_req(8'($urandom), 1'b1));
		repeat (40) plan(tick_req());
		settle();
		sender_steady <= 1'b0;
		settle();

		$display("Run covered %0d requests: %0d ticks, %0d byte deliveries, %0d frame starts",
			ticks_taken + bytes_taken, ticks_taken, bytes_taken, frames_started);
		$display("%0d samples checked over %0d register settings, %0d mismatches",
			samples_checked, settings_used, mismatches);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
